>>> src/pbd_pkg.sv
`default_nettype none

package pbd_pkg;

    // Defaults for the top level parameters.
    localparam int MaxInputSizeDefault  = 1024;
    localparam int LandmarkCountDefault = 5;

    // Field widths.
    localparam int MarkW  = 12;
    localparam int CoordW = 18;
    localparam int QuoW   = 18;
    localparam int DivW   = 32;
    localparam int MulAW  = 28;
    localparam int MulBW  = 21;
    localparam int ProdW  = MulAW + MulBW;

    // Fixed-point gains: 0.1 in Q0.16 and 0.2*log2(e) in Q0.16.
    localparam logic [12:0] BoxGain = 13'd6554;
    localparam logic [14:0] ExpGain = 15'd18910;
    localparam logic [19:0] ExpBias = 20'd262144;

    // Horner coefficients of the 2^f polynomial, Q16.
    localparam logic [17:0] HornerC0 = 18'd5125;
    localparam logic [17:0] HornerC1 = 18'd14824;
    localparam logic [17:0] HornerC2 = 18'd45592;
    localparam logic [17:0] HornerC3 = 18'd65536;

    // Saturation limits of a pixel coordinate.
    localparam logic [CoordW-1:0] CoordMax = 18'h1FFFF;
    localparam logic [CoordW-1:0] CoordMin = 18'h20000;

    // Configuration reset values.
    localparam logic [10:0] HeightReset = 11'd640;
    localparam logic [10:0] WidthReset  = 11'd640;
    localparam logic [15:0] ThreshReset = 16'd32768;
    localparam logic [19:0] ScaleReset  = 20'd163840;

    // Steps of the box preparation sequence.
    localparam logic [3:0] StepDx  = 4'd0;
    localparam logic [3:0] StepDy  = 4'd1;
    localparam logic [3:0] StepDw  = 4'd2;
    localparam logic [3:0] StepW1  = 4'd3;
    localparam logic [3:0] StepW2  = 4'd4;
    localparam logic [3:0] StepW3  = 4'd5;
    localparam logic [3:0] StepHw  = 4'd6;
    localparam logic [3:0] StepDh  = 4'd7;
    localparam logic [3:0] StepH1  = 4'd8;
    localparam logic [3:0] StepH2  = 4'd9;
    localparam logic [3:0] StepH3  = 4'd10;
    localparam logic [3:0] StepHh  = 4'd11;

    typedef enum logic [2:0] {
        CFG_INPUT_HEIGHT    = 3'd0,
        CFG_INPUT_WIDTH     = 3'd1,
        CFG_SCORE_THRESHOLD = 3'd2,
        CFG_PIXEL_SCALE_X   = 3'd3,
        CFG_PIXEL_SCALE_Y   = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_LMUL,
        S_CMUL,
        S_DLOAD,
        S_DWAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  level;
        logic [7:0]  row;
        logic [7:0]  column;
        logic        size_sel;
        logic [15:0] prior;
    } anchor_t;

    typedef struct packed {
        logic            done;
        logic            overflow;
        logic [QuoW-1:0] quotient;
    } div_result_t;

endpackage

`default_nettype wire

>>> src/prior_box_decode_core.sv
// Prior box decoder for a three-level face detector.
//
// The s_ channel takes one prior per item: score, four box offsets and the
// packed landmark offsets, with tlast marking the last prior of a frame.
// Priors scoring below the threshold produce nothing. A passing prior
// produces one box item (tuser low) and then one item per landmark
// (tuser high), the last of them with tlast set. The cfg channel is always
// ready; registers are to be written while idle, which the block does not enforce.
//
// A rejected prior is taken without leaving the idle state. A passing prior
// runs through one shared multiplier and one serial divider: a preparation
// sequence for the box, then a multiply and a division per coordinate of the box
// item and of each landmark item. The 18-step divider dominates each coordinate.
// The block takes no new prior until the last item of the current one has
// been taken. While the receiver stalls, the pending item is held.
// Reset restores the register defaults and clears the anchor counters.
`default_nettype none

module prior_box_decode_core #(
    parameter int MAX_INPUT_SIZE = pbd_pkg::MaxInputSizeDefault,
    parameter int LANDMARK_COUNT = pbd_pkg::LandmarkCountDefault
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // face_score, offset_x, offset_y, offset_w, offset_h, mark_dx_packed, mark_dy_packed
    input  wire logic [199:0] s_tdata,
    input  wire logic         s_tlast,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // coord_a, coord_b, coord_c, coord_d, score_out, prior_number
    output logic [103:0]      m_tdata,
    // kind
    output logic              m_tuser,
    output logic              m_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [19:0]  cfg_data
);

    localparam int SizeW    = $clog2(MAX_INPUT_SIZE + 1);
    localparam int MarkIdxW = $clog2(LANDMARK_COUNT + 1);
    localparam int MarkW    = pbd_pkg::MarkW;
    localparam int CoordW   = pbd_pkg::CoordW;
    localparam int ProdW    = pbd_pkg::ProdW;
    localparam logic [MarkIdxW-1:0] MarkLast = MarkIdxW'(LANDMARK_COUNT - 1);

    // Configuration registers.
    logic [10:0] height_reg, width_reg;
    logic [15:0] thresh_reg;
    logic [19:0] scale_x_reg, scale_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg  <= pbd_pkg::HeightReset;
            width_reg   <= pbd_pkg::WidthReset;
            thresh_reg  <= pbd_pkg::ThreshReset;
            scale_x_reg <= pbd_pkg::ScaleReset;
            scale_y_reg <= pbd_pkg::ScaleReset;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pbd_pkg::CFG_INPUT_HEIGHT:    height_reg  <= cfg_data[10:0];
                pbd_pkg::CFG_INPUT_WIDTH:     width_reg   <= cfg_data[10:0];
                pbd_pkg::CFG_SCORE_THRESHOLD: thresh_reg  <= cfg_data[15:0];
                pbd_pkg::CFG_PIXEL_SCALE_X:   scale_x_reg <= cfg_data;
                pbd_pkg::CFG_PIXEL_SCALE_Y:   scale_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective sizes, clamped to the supported range.
    logic [SizeW-1:0] heff, weff;

    always_comb begin
        if (height_reg == '0) begin
            heff = SizeW'(1);
        end else if (32'(height_reg) > MAX_INPUT_SIZE) begin
            heff = SizeW'(MAX_INPUT_SIZE);
        end else begin
            heff = SizeW'(height_reg);
        end
        if (width_reg == '0) begin
            weff = SizeW'(1);
        end else if (32'(width_reg) > MAX_INPUT_SIZE) begin
            weff = SizeW'(MAX_INPUT_SIZE);
        end else begin
            weff = SizeW'(width_reg);
        end
    end

    // Anchor counters.
    logic             in_accept;
    pbd_pkg::anchor_t anc;
    logic [1:0]       lvl;

    assign in_accept = s_tvalid && s_tready;
    assign lvl       = (anc.level == 2'd3) ? 2'd0 : anc.level;

    pbd_anchor #(
        .MAX_INPUT_SIZE(MAX_INPUT_SIZE)
    ) u_anchor (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (in_accept),
        .frame_end(s_tlast),
        .heff     (heff),
        .weff     (weff),
        .anchor   (anc)
    );

    // Sequencer and datapath registers.
    pbd_pkg::state_t state_reg, state_next;
    logic                 mark_reg, mark_next;
    logic [MarkIdxW-1:0]  k_reg, k_next;
    logic [3:0]           step_reg, step_next;
    logic [1:0]           cidx_reg, cidx_next;
    logic [15:0]          score_reg, score_next;
    logic [15:0]          number_reg, number_next;
    logic signed [15:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic signed [15:0]   dw_reg, dw_next, dh_reg, dh_next;
    logic [59:0]          markx_reg, markx_next, marky_reg, marky_next;
    logic [3:0]           mlog_reg, mlog_next;
    logic [25:0]          cx_reg, cx_next, cy_reg, cy_next;
    logic [15:0]          f_reg, f_next;
    logic [2:0]           n_reg, n_next;
    logic [17:0]          hp_reg, hp_next;
    logic [26:0]          bx_reg, bx_next, by_reg, by_next;
    logic [25:0]          hw_reg, hw_next, hh_reg, hh_next;
    logic [26:0]          lx_reg, lx_next, ly_reg, ly_next;
    logic [31:0]          t_reg, t_next;
    logic                 neg_reg, neg_next;
    logic [CoordW-1:0]    ca_reg, ca_next, cb_reg, cb_next;
    logic [CoordW-1:0]    cc_reg, cc_next, cd_reg, cd_next;

    // The shared multiplier and its operand select.
    logic signed [pbd_pkg::MulAW-1:0] mul_a;
    logic signed [pbd_pkg::MulBW-1:0] mul_b;
    logic signed [ProdW-1:0]          prod;
    logic                             prod_neg;
    logic [ProdW-1:0]                 prod_mag;

    assign prod     = mul_a * mul_b;
    assign prod_neg = prod[ProdW-1];
    assign prod_mag = prod_neg ? ProdW'(-prod) : ProdW'(prod);

    // Rounded shifts by the anchor size for box and landmark offsets.
    logic [37:0] shl;
    logic [21:0] box_rnd;
    logic [25:0] mk_rnd;
    logic [26:0] box_shift, mk_shift, ctr;

    assign shl       = 38'(prod_mag[28:0]) << mlog_reg;
    assign box_rnd   = 22'((shl + 38'd32768) >> 16);
    assign mk_rnd    = 26'((shl + 38'd2048) >> 12);
    assign box_shift = prod_neg ? 27'd0 - 27'(box_rnd) : 27'(box_rnd);
    assign mk_shift  = prod_neg ? 27'd0 - 27'(mk_rnd) : 27'(mk_rnd);
    assign ctr       = step_reg[0] ? {1'b0, cy_reg} : {1'b0, cx_reg};

    // Exponent argument split into integer and fraction.
    logic [17:0] uq;
    logic [19:0] u_val;

    assign uq    = 18'((prod_mag[29:0] + 30'd2048) >> 12);
    assign u_val = prod_neg ? pbd_pkg::ExpBias - 20'(uq) : pbd_pkg::ExpBias + 20'(uq);

    // Horner step and the final power-of-two scaling.
    logic [17:0] horner_c;
    logic [17:0] hp_calc;
    logic [20:0] e_val;
    logic [25:0] half_calc;

    always_comb begin
        unique case (step_reg)
            pbd_pkg::StepW1, pbd_pkg::StepH1: horner_c = pbd_pkg::HornerC1;
            pbd_pkg::StepW2, pbd_pkg::StepH2: horner_c = pbd_pkg::HornerC2;
            default:                          horner_c = pbd_pkg::HornerC3;
        endcase
    end

    assign hp_calc   = horner_c + prod_mag[33:16];
    assign e_val     = (n_reg >= 3'd4) ? 21'(hp_reg) << (n_reg - 3'd4)
                                       : 21'(hp_reg) >> (3'd4 - n_reg);
    assign half_calc = 26'(((31'(e_val) << mlog_reg) + 31'd16) >> 5);

    // Value to convert to pixels, its scale and its norm.
    logic signed [27:0] n_val;
    logic signed [27:0] base_val, half_val;
    logic [19:0]        scale_sel;
    logic [SizeW-1:0]   norm_sel;
    logic [47:0]        t_full;

    assign base_val  = cidx_reg[0] ? 28'($signed(by_reg)) : 28'($signed(bx_reg));
    assign half_val  = cidx_reg[0] ? $signed({2'b0, hh_reg}) : $signed({2'b0, hw_reg});
    assign scale_sel = cidx_reg[0] ? scale_y_reg : scale_x_reg;
    assign norm_sel  = cidx_reg[0] ? weff : heff;
    assign t_full    = prod_mag[47:0] + (48'(norm_sel) << 15);

    always_comb begin
        if (mark_reg) begin
            n_val = cidx_reg[0] ? 28'($signed(ly_reg)) : 28'($signed(lx_reg));
        end else begin
            n_val = cidx_reg[1] ? base_val + half_val : base_val - half_val;
        end
    end

    // Serial divider for the pixel conversion.
    pbd_pkg::div_result_t div_res;
    logic                 div_start;
    logic [CoordW-1:0]    coord_sat;

    assign div_start = (state_reg == pbd_pkg::S_DLOAD);

    pbd_div #(
        .MAX_INPUT_SIZE(MAX_INPUT_SIZE)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(t_reg),
        .divisor (norm_sel),
        .result  (div_res)
    );

    // Sign and saturation of the rounded quotient.
    always_comb begin
        if (div_res.overflow) begin
            coord_sat = neg_reg ? pbd_pkg::CoordMin : pbd_pkg::CoordMax;
        end else if (!neg_reg) begin
            coord_sat = div_res.quotient[CoordW-1] ? pbd_pkg::CoordMax : div_res.quotient;
        end else if (div_res.quotient > pbd_pkg::CoordMin) begin
            coord_sat = pbd_pkg::CoordMin;
        end else begin
            coord_sat = CoordW'(0) - div_res.quotient;
        end
    end

    // Next state, operand select and register updates.
    always_comb begin
        state_next  = state_reg;
        mark_next   = mark_reg;
        k_next      = k_reg;
        step_next   = step_reg;
        cidx_next   = cidx_reg;
        score_next  = score_reg;
        number_next = number_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        dw_next     = dw_reg;
        dh_next     = dh_reg;
        markx_next  = markx_reg;
        marky_next  = marky_reg;
        mlog_next   = mlog_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        f_next      = f_reg;
        n_next      = n_reg;
        hp_next     = hp_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        hw_next     = hw_reg;
        hh_next     = hh_reg;
        lx_next     = lx_reg;
        ly_next     = ly_reg;
        t_next      = t_reg;
        neg_next    = neg_reg;
        ca_next     = ca_reg;
        cb_next     = cb_reg;
        cc_next     = cc_reg;
        cd_next     = cd_reg;
        mul_a       = '0;
        mul_b       = '0;
        s_tready    = 1'b0;

        unique case (state_reg)
            pbd_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    score_next  = s_tdata[15:0];
                    number_next = anc.prior;
                    dx_next     = s_tdata[31:16];
                    dy_next     = s_tdata[47:32];
                    dw_next     = s_tdata[63:48];
                    dh_next     = s_tdata[79:64];
                    markx_next  = s_tdata[139:80];
                    marky_next  = s_tdata[199:140];
                    mlog_next   = 4'd4 + {1'b0, lvl, 1'b0} + {3'b0, anc.size_sel};
                    cx_next     = 26'({anc.column, 1'b1}) << (5'd14 + {3'b0, lvl});
                    cy_next     = 26'({anc.row, 1'b1}) << (5'd14 + {3'b0, lvl});
                    if (s_tdata[15:0] >= thresh_reg) begin
                        mark_next  = 1'b0;
                        step_next  = pbd_pkg::StepDx;
                        state_next = pbd_pkg::S_PREP;
                    end
                end
            end

            pbd_pkg::S_PREP: begin
                step_next = step_reg + 4'd1;
                unique case (step_reg)
                    pbd_pkg::StepDx: begin
                        mul_a   = 28'(dx_reg);
                        mul_b   = 21'(pbd_pkg::BoxGain);
                        bx_next = ctr + box_shift;
                    end
                    pbd_pkg::StepDy: begin
                        mul_a   = 28'(dy_reg);
                        mul_b   = 21'(pbd_pkg::BoxGain);
                        by_next = ctr + box_shift;
                    end
                    pbd_pkg::StepDw, pbd_pkg::StepDh: begin
                        mul_a  = (step_reg == pbd_pkg::StepDw) ? 28'(dw_reg) : 28'(dh_reg);
                        mul_b  = 21'(pbd_pkg::ExpGain);
                        n_next = u_val[18:16];
                        f_next = u_val[15:0];
                    end
                    pbd_pkg::StepW1, pbd_pkg::StepH1: begin
                        mul_a   = 28'(pbd_pkg::HornerC0);
                        mul_b   = 21'(f_reg);
                        hp_next = hp_calc;
                    end
                    pbd_pkg::StepW2, pbd_pkg::StepW3, pbd_pkg::StepH2, pbd_pkg::StepH3: begin
                        mul_a   = 28'(hp_reg);
                        mul_b   = 21'(f_reg);
                        hp_next = hp_calc;
                    end
                    pbd_pkg::StepHw: begin
                        hw_next = half_calc;
                    end
                    pbd_pkg::StepHh: begin
                        hh_next    = half_calc;
                        cidx_next  = 2'd0;
                        state_next = pbd_pkg::S_CMUL;
                    end
                    default: ;
                endcase
            end

            pbd_pkg::S_LMUL: begin
                mul_b = 21'(pbd_pkg::BoxGain);
                if (!step_reg[0]) begin
                    mul_a     = 28'($signed(markx_reg[MarkW-1:0]));
                    lx_next   = ctr + mk_shift;
                    step_next = step_reg + 4'd1;
                end else begin
                    mul_a      = 28'($signed(marky_reg[MarkW-1:0]));
                    ly_next    = ctr + mk_shift;
                    cidx_next  = 2'd0;
                    state_next = pbd_pkg::S_CMUL;
                end
            end

            pbd_pkg::S_CMUL: begin
                mul_a      = n_val;
                mul_b      = $signed({1'b0, scale_sel});
                t_next     = t_full[47:16];
                neg_next   = prod_neg;
                state_next = pbd_pkg::S_DLOAD;
            end

            pbd_pkg::S_DLOAD: begin
                state_next = pbd_pkg::S_DWAIT;
            end

            pbd_pkg::S_DWAIT: begin
                if (div_res.done) begin
                    unique case (cidx_reg)
                        2'd0:    ca_next = coord_sat;
                        2'd1:    cb_next = coord_sat;
                        2'd2:    cc_next = coord_sat;
                        default: cd_next = coord_sat;
                    endcase
                    if ((mark_reg && cidx_reg == 2'd1) || cidx_reg == 2'd3) begin
                        state_next = pbd_pkg::S_OUT;
                    end else begin
                        cidx_next  = cidx_reg + 2'd1;
                        state_next = pbd_pkg::S_CMUL;
                    end
                end
            end

            pbd_pkg::S_OUT: begin
                if (m_tready) begin
                    step_next = pbd_pkg::StepDx;
                    if (!mark_reg) begin
                        mark_next  = 1'b1;
                        k_next     = '0;
                        cc_next    = '0;
                        cd_next    = '0;
                        state_next = pbd_pkg::S_LMUL;
                    end else if (k_reg == MarkLast) begin
                        state_next = pbd_pkg::S_IDLE;
                    end else begin
                        k_next     = k_reg + MarkIdxW'(1);
                        markx_next = markx_reg >> MarkW;
                        marky_next = marky_reg >> MarkW;
                        state_next = pbd_pkg::S_LMUL;
                    end
                end
            end

            default: begin
                state_next = pbd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pbd_pkg::S_IDLE;
            mark_reg  <= 1'b0;
            k_reg     <= '0;
            step_reg  <= '0;
            cidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            mark_reg  <= mark_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
            cidx_reg  <= cidx_next;
        end
        score_reg  <= score_next;
        number_reg <= number_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dw_reg     <= dw_next;
        dh_reg     <= dh_next;
        markx_reg  <= markx_next;
        marky_reg  <= marky_next;
        mlog_reg   <= mlog_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        f_reg      <= f_next;
        n_reg      <= n_next;
        hp_reg     <= hp_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        hw_reg     <= hw_next;
        hh_reg     <= hh_next;
        lx_reg     <= lx_next;
        ly_reg     <= ly_next;
        t_reg      <= t_next;
        neg_reg    <= neg_next;
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
        cc_reg     <= cc_next;
        cd_reg     <= cd_next;
    end

    // Result item.
    assign m_tvalid = (state_reg == pbd_pkg::S_OUT);
    assign m_tdata  = {number_reg, score_reg, cd_reg, cc_reg, cb_reg, ca_reg};
    assign m_tuser  = mark_reg;
    assign m_tlast  = mark_reg && (k_reg == MarkLast);

    // Checks on the sequencer.
    a_one_prior_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result item is pending");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == pbd_pkg::S_DWAIT))
        else $error("divider finished outside the wait state");

    a_last_is_landmark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("end of run on a box item");

    a_ready_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after the last item of a prior");

endmodule

`default_nettype wire

>>> src/pbd_anchor.sv
`default_nettype none

module pbd_anchor #(
    parameter int MAX_INPUT_SIZE = pbd_pkg::MaxInputSizeDefault
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 advance,
    input  wire logic                                 frame_end,
    input  wire logic [$clog2(MAX_INPUT_SIZE+1)-1:0]  heff,
    input  wire logic [$clog2(MAX_INPUT_SIZE+1)-1:0]  weff,
    output pbd_pkg::anchor_t                          anchor
);

    localparam int SizeW = $clog2(MAX_INPUT_SIZE + 1);
    localparam int CntW  = SizeW + 1;
    localparam int CmpW  = (CntW > 9) ? CntW : 9;

    pbd_pkg::anchor_t anchor_reg, anchor_next;
    logic [1:0]      lvl;
    logic [2:0]      sh;
    logic [CntW-1:0] round_up;
    logic [CmpW-1:0] rows, cols;

    // Feature map size of the current level, rounded up.
    assign lvl      = (anchor_reg.level == 2'd3) ? 2'd0 : anchor_reg.level;
    assign sh       = 3'd3 + {1'b0, lvl};
    assign round_up = (CntW'(1) << sh) - CntW'(1);
    assign rows     = CmpW'((CntW'(heff) + round_up) >> sh);
    assign cols     = CmpW'((CntW'(weff) + round_up) >> sh);

    // Size, then column, then row, then level; a frame end clears all.
    always_comb begin
        anchor_next = anchor_reg;
        if (advance) begin
            anchor_next.prior = anchor_reg.prior + 16'd1;
            if (!anchor_reg.size_sel) begin
                anchor_next.size_sel = 1'b1;
            end else begin
                anchor_next.size_sel = 1'b0;
                if (CmpW'(anchor_reg.column) + CmpW'(1) < cols) begin
                    anchor_next.column = anchor_reg.column + 8'd1;
                end else begin
                    anchor_next.column = '0;
                    if (CmpW'(anchor_reg.row) + CmpW'(1) < rows) begin
                        anchor_next.row = anchor_reg.row + 8'd1;
                    end else begin
                        anchor_next.row   = '0;
                        anchor_next.level = (lvl == 2'd2) ? 2'd0 : lvl + 2'd1;
                    end
                end
            end
            if (frame_end) begin
                anchor_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anchor_reg <= '0;
        end else begin
            anchor_reg <= anchor_next;
        end
    end

    assign anchor = anchor_reg;

endmodule

`default_nettype wire

>>> src/pbd_div.sv
`default_nettype none

module pbd_div #(
    parameter int MAX_INPUT_SIZE = pbd_pkg::MaxInputSizeDefault
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic [pbd_pkg::DivW-1:0]             dividend,
    input  wire logic [$clog2(MAX_INPUT_SIZE+1)-1:0]  divisor,
    output pbd_pkg::div_result_t                      result
);

    localparam int SizeW = $clog2(MAX_INPUT_SIZE + 1);
    localparam int QuoW  = pbd_pkg::QuoW;
    localparam int HiW   = pbd_pkg::DivW - QuoW;
    localparam int CntW  = $clog2(QuoW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic [SizeW-1:0]  rem_reg, rem_next;
    logic [QuoW-1:0]   quo_reg, quo_next;
    logic [HiW-1:0]    hi;
    logic [SizeW:0]    trial, diff;
    logic              fits;

    // One quotient bit a cycle, restoring form.
    assign hi    = dividend[pbd_pkg::DivW-1:QuoW];
    assign trial = {rem_reg, quo_reg[QuoW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            // A high part at or above the divisor means the quotient needs more bits.
            ovf_next  = hi >= HiW'(divisor);
            rem_next  = hi[SizeW-1:0];
            quo_next  = dividend[QuoW-1:0];
            cnt_next  = CntW'(QuoW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[SizeW-1:0] : trial[SizeW-1:0];
            quo_next = {quo_reg[QuoW-2:0], fits};
            cnt_next = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        ovf_reg <= ovf_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign result.done     = done_reg;
    assign result.overflow = ovf_reg;
    assign result.quotient = quo_reg;

endmodule

`default_nettype wire
